/* hdl/smpq_pkg.sv */
package smpq_pkg;

	// Operation carried by an input item
	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} smpq_cmd_t;

	// Outcome reported with every result item
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DEQ_EMPTY = 2'd1,
		ST_ENQ_FULL  = 2'd2
	} smpq_status_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;	// insert the broadcast value at its sorted place
		logic deq;	// drop the head, shift every entry one cell toward it
	} smpq_ctl_t;

endpackage

/* hdl/smpq_ifs.sv */
interface smpq_req_if #(
	parameter int DATA_W = 32
);
	logic                       valid;
	logic                       ready;
	smpq_pkg::smpq_cmd_t        cmd;
	logic signed [DATA_W-1:0]   value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);
endinterface

interface smpq_rsp_if #(
	parameter int DATA_W  = 32,
	parameter int COUNT_W = 7
);
	logic                       valid;
	logic                       ready;
	logic signed [DATA_W-1:0]   result_value;
	logic [COUNT_W-1:0]         entry_count;
	logic                       queue_empty;
	smpq_pkg::smpq_status_t     status;

	modport source (output valid, result_value, entry_count, queue_empty, status,
		input ready);
	modport sink   (input valid, result_value, entry_count, queue_empty, status,
		output ready);
endinterface

/* hdl/smpq_cell.sv */
module smpq_cell #(
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  smpq_pkg::smpq_ctl_t      ctl,
	input  logic signed [WIDTH-1:0]  new_value,
	input  logic                     occupied,
	input  logic                     prev_keeps,
	input  logic signed [WIDTH-1:0]  prev_value,
	input  logic signed [WIDTH-1:0]  next_value,
	output logic signed [WIDTH-1:0]  value,
	output logic                     keeps
);

	logic signed [WIDTH-1:0] value_q;

	// Hold when this entry sorts ahead of the new value (ties stay ahead)
	assign keeps = occupied && (value_q >= new_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (!keeps) begin
				value_q <= prev_keeps ? new_value : prev_value;
			end
		end else if (ctl.deq) begin
			value_q <= next_value;
		end
	end

endmodule

/* hdl/sorted_max_priority_queue.sv */
// Channel | Dir | Handshake      | Payload
// req     | in  | valid / ready  | cmd, value
// rsp     | out | valid / ready  | result_value, entry_count, queue_empty, status
//
// One item per cycle unless the output stalls: the item is decided in the cycle it
// is accepted and its result sits in the output register on the next cycle.
// All DEPTH cells of the chain update together; the broadcast compare across
// all cells plus the head compare set the cycle time.
// Reset clears the entry count and the output valid; cell contents need none.
// req.ready drops only while a result waits and rsp.ready is low.
module sorted_max_priority_queue #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	smpq_req_if.sink    req,
	smpq_rsp_if.source  rsp
);

	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OUT_CNT_W = $bits(rsp.entry_count);

	// Entry count and output register
	logic [CNT_W-1:0]          count_q;
	logic                      out_valid_q;
	logic signed [WIDTH-1:0]   res_value_q;
	logic [CNT_W-1:0]          res_count_q;
	smpq_pkg::smpq_status_t    res_status_q;

	// Cell chain, index 0 holds the maximum
	logic signed [WIDTH-1:0]   cell_value [DEPTH];
	logic                      cell_keeps [DEPTH];
	smpq_pkg::smpq_ctl_t       ctl;

	logic                      fire;
	logic                      is_enq;
	logic                      cnt_zero;
	logic                      cnt_full;
	logic signed [WIDTH-1:0]   new_value;
	logic signed [WIDTH-1:0]   head;
	logic signed [WIDTH-1:0]   res_value;
	logic [CNT_W-1:0]          count_next;
	smpq_pkg::smpq_status_t    res_status;

	// Take a new item whenever the output register is free or being drained
	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_enq    = (req.cmd == smpq_pkg::CMD_ENQUEUE);
	assign new_value = req.value;
	assign head      = cell_value[0];
	assign cnt_zero  = (count_q == '0);
	assign cnt_full  = (count_q == CNT_W'(DEPTH));

	// Drop enqueues into a full chain and dequeues from an empty one
	assign ctl.enq = fire && is_enq && !cnt_full;
	assign ctl.deq = fire && !is_enq && !cnt_zero;

	always_comb begin
		count_next = count_q;
		res_status = smpq_pkg::ST_OK;
		res_value  = head;
		if (is_enq) begin
			if (cnt_full) begin
				res_status = smpq_pkg::ST_ENQ_FULL;
			end else begin
				count_next = count_q + 1'b1;
				// New maximum when the queue was empty or the value beats the head
				if (cnt_zero || (new_value > head)) begin
					res_value = new_value;
				end
			end
		end else begin
			if (cnt_zero) begin
				res_status = smpq_pkg::ST_DEQ_EMPTY;
				res_value  = '0;
			end else begin
				count_next = count_q - 1'b1;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                    occupied;
			logic                    prev_keeps;
			logic signed [WIDTH-1:0] prev_value;
			logic signed [WIDTH-1:0] next_value;

			assign occupied = (count_q > CNT_W'(gi));

			if (gi == 0) begin : g_first
				// The head takes the new value whenever it does not hold
				assign prev_keeps = 1'b1;
				assign prev_value = new_value;
			end else begin : g_mid
				assign prev_keeps = cell_keeps[gi-1];
				assign prev_value = cell_value[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign next_value = '0;
			end else begin : g_tail
				assign next_value = cell_value[gi+1];
			end

			smpq_cell #(
				.WIDTH (WIDTH)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_value  (new_value),
				.occupied   (occupied),
				.prev_keeps (prev_keeps),
				.prev_value (prev_value),
				.next_value (next_value),
				.value      (cell_value[gi]),
				.keeps      (cell_keeps[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result of the accepted item
	always_ff @(posedge clk) begin
		if (fire) begin
			res_value_q  <= res_value;
			res_count_q  <= count_next;
			res_status_q <= res_status;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = res_value_q;
	assign rsp.entry_count  = OUT_CNT_W'(res_count_q);
	assign rsp.queue_empty  = (res_count_q == '0);
	assign rsp.status       = res_status_q;

	// Count never passes the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	// An accepted enqueue into a non-full chain grows the count by one
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.enq |=> (count_q == $past(count_q) + 1'b1))
		else $error("enqueue did not grow the count");

	// Head and its neighbor stay in descending order
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_value[0] >= cell_value[1]))
		else $error("chain head out of order");

	// A dequeue on an empty queue reports an empty queue and a zero value
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_status_q == smpq_pkg::ST_DEQ_EMPTY))
			|-> (res_count_q == '0 && res_value_q == '0))
		else $error("empty dequeue result inconsistent");

endmodule

/* tb/sorted_max_priority_queue_test.sv */
module sorted_max_priority_queue_test;

	localparam int STORE_DEPTH = 64;
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 7;
	// Cycles with no item moving on either channel before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 200;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	// One expected result item
	typedef struct {
		logic signed [VALUE_W-1:0] top_value;
		logic [COUNT_W-1:0]        count;
		logic                      empty;
		smpq_pkg::smpq_status_t    status;
	} queue_result_t;

	logic clk;
	logic arst_n;

	smpq_req_if #(.DATA_W(VALUE_W)) req_ch ();
	smpq_rsp_if #(.DATA_W(VALUE_W), .COUNT_W(COUNT_W)) rsp_ch ();

	sorted_max_priority_queue #(
		.DEPTH(STORE_DEPTH),
		.WIDTH(VALUE_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow of the store, ascending from index 0; its size is the entry count.
	logic signed [VALUE_W-1:0] sorted_store[$];
	// Results owed by the block, oldest first.
	queue_result_t pending_results[$];

	int fail_count = 0;
	// When set, the matching side never idles at random; a receiver hold-off still wins.
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;
	// Cycles the receiver still has to hold off; counted down by the receiver itself.
	int rsp_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one operation to the shadow store and return the result it must produce.
	function automatic queue_result_t apply_queue_op(smpq_pkg::smpq_cmd_t op,
			logic signed [VALUE_W-1:0] v);
		queue_result_t r;
		int slot;
		r.status    = smpq_pkg::ST_OK;
		r.top_value = '0;
		if (op == smpq_pkg::CMD_ENQUEUE) begin
			if (sorted_store.size() >= STORE_DEPTH) begin
				// Full: drop the value, report the current maximum.
				r.status = smpq_pkg::ST_ENQ_FULL;
			end else begin
				// Insert after any equal entries.
				slot = sorted_store.size();
				while (slot > 0 && sorted_store[slot-1] > v)
					slot--;
				sorted_store.insert(slot, v);
			end
			if (sorted_store.size() > 0)
				r.top_value = sorted_store[sorted_store.size()-1];
		end else begin
			if (sorted_store.size() == 0)
				r.status = smpq_pkg::ST_DEQ_EMPTY;
			else
				r.top_value = sorted_store.pop_back();
		end
		r.count = COUNT_W'(sorted_store.size());
		r.empty = (sorted_store.size() == 0);
		return r;
	endfunction

	// Small values a quarter of the time so that duplicates are common, some extremes, the rest anywhere.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 25)
			return $signed($urandom_range(8)) - 4;
		if (sel < 37) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom();
	endfunction

	// Offer one item at the falling edge, hold it until accepted, then predict its result.
	// Valid stays high into the next call, so it does not drop between back-to-back items.
	task automatic send_item(smpq_pkg::smpq_cmd_t op, logic signed [VALUE_W-1:0] v);
		int gap;
		gap = 0;
		if (!sender_steady && $urandom_range(99) < 16)
			gap = $urandom_range(1, 4);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= op;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(apply_queue_op(op, v));
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_dequeue();
		// Dequeue on a fresh queue, then again with every value bit set.
		send_item(smpq_pkg::CMD_DEQUEUE, '0);
		send_item(smpq_pkg::CMD_DEQUEUE, -1);
		drain_results();
	endtask

	task automatic test_extremes();
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MIN);
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MAX);
		send_item(smpq_pkg::CMD_ENQUEUE, '0);
		send_item(smpq_pkg::CMD_ENQUEUE, -1);
		// Equal entries stack up and must come back one by one.
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MAX);
		send_item(smpq_pkg::CMD_ENQUEUE, 32'sd5);
		send_item(smpq_pkg::CMD_ENQUEUE, 32'sd5);
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MIN);
		send_item(smpq_pkg::CMD_ENQUEUE, 32'sh5555_5555);
		repeat (9)
			send_item(smpq_pkg::CMD_DEQUEUE, $urandom());
		// One extra dequeue past empty.
		send_item(smpq_pkg::CMD_DEQUEUE, VAL_MAX);
		drain_results();
	endtask

	task automatic test_full_store();
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MIN);
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MAX);
		repeat (STORE_DEPTH - 2)
			send_item(smpq_pkg::CMD_ENQUEUE, pick_value());
		// Store is full: these are dropped.
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MAX);
		send_item(smpq_pkg::CMD_ENQUEUE, VAL_MIN);
		send_item(smpq_pkg::CMD_ENQUEUE, pick_value());
		// Free one slot, refill it, then overflow again.
		send_item(smpq_pkg::CMD_DEQUEUE, $urandom());
		send_item(smpq_pkg::CMD_ENQUEUE, pick_value());
		send_item(smpq_pkg::CMD_ENQUEUE, pick_value());
		repeat (STORE_DEPTH + 1)
			send_item(smpq_pkg::CMD_DEQUEUE, $urandom());
		drain_results();
	endtask

	task automatic test_output_backpressure();
		// Hold the receiver off while items keep coming; the block must stall its input.
		rsp_hold_cycles = LONG_HOLD;
		repeat (20)
			send_item(($urandom_range(99) < 70) ? smpq_pkg::CMD_ENQUEUE
				: smpq_pkg::CMD_DEQUEUE, pick_value());
		drain_results();
	endtask

	task automatic test_random_traffic();
		int phase;
		int enq_pct;
		for (phase = 0; phase < 10; phase++) begin
			// Rotate the bias between mostly enqueues, an even mix and mostly dequeues.
			case (phase % 3)
				0: enq_pct = 85;
				1: enq_pct = 50;
				default: enq_pct = 20;
			endcase
			// One phase runs with no idling on either side.
			sender_steady   = (phase == 4);
			receiver_steady = (phase == 4);
			if (phase == 8)
				rsp_hold_cycles = 60;
			repeat (36) begin
				if ($urandom_range(99) < enq_pct)
					send_item(smpq_pkg::CMD_ENQUEUE, pick_value());
				else
					send_item(smpq_pkg::CMD_DEQUEUE, $urandom());
			end
			// Pause the sender mid-run until the block is idle.
			if (phase == 5)
				drain_results();
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		drain_results();
	endtask

	// Receiver: drive ready at the falling edge, honoring any requested hold-off.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_cycles--;
			end else begin
				rsp_ch.ready <= receiver_steady || ($urandom_range(99) >= 16);
			end
		end
	end

	// Compare each accepted result with the oldest prediction.
	initial begin
		queue_result_t exp_r;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: value %0d count %0d",
						rsp_ch.result_value, rsp_ch.entry_count);
					fail_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (rsp_ch.result_value !== exp_r.top_value) begin
						$error("result_value: expected %0d, actual %0d",
							exp_r.top_value, rsp_ch.result_value);
						fail_count++;
					end
					if (rsp_ch.entry_count !== exp_r.count) begin
						$error("entry_count: expected %0d, actual %0d",
							exp_r.count, rsp_ch.entry_count);
						fail_count++;
					end
					if (rsp_ch.queue_empty !== exp_r.empty) begin
						$error("queue_empty: expected %0b, actual %0b",
							exp_r.empty, rsp_ch.queue_empty);
						fail_count++;
					end
					if (rsp_ch.status !== exp_r.status) begin
						$error("status: expected %0d, actual %0d",
							exp_r.status, rsp_ch.status);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin : hang_guard
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("sorted_max_priority_queue regression: fail");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = smpq_pkg::CMD_ENQUEUE;
		req_ch.value = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_dequeue();
		test_extremes();
		test_full_store();
		test_output_backpressure();
		test_random_traffic();

		// Let any stray result show up before judging.
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("sorted_max_priority_queue regression: pass");
		else
			$display("sorted_max_priority_queue regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
hdl/smpq_pkg.sv
hdl/smpq_ifs.sv
hdl/smpq_cell.sv
hdl/sorted_max_priority_queue.sv
tb/sorted_max_priority_queue_test.sv
